// File: rtl/bhsa_pkg.sv
// ============================================================================
// bhsa_pkg: shared types and constants of the harmonic-sum accumulator
// Holds bin tables, CORDIC angle constants, controller states and the
// command/status structs between the controller and the datapath.
// ============================================================================
package bhsa_pkg;

  localparam int PT_BINS_DEF   = 20;
  localparam int ETA_BINS_DEF  = 12;
  localparam int CENT_BINS_DEF = 200;
  localparam int ACC_WIDTH_DEF = 48;

  localparam int PT_EDGE_NUM   = 21;
  localparam int CORDIC_STEPS  = 16;
  localparam int ETA_OFFSET    = 2400;
  localparam int ETA_STEP      = 400;

  localparam logic signed [11:0] MIN_AZ_RST = -12'sd960;
  localparam logic signed [11:0] MAX_AZ_RST = 12'sd960;

  localparam logic CFG_MIN_AZ = 1'b0;
  localparam logic CFG_MAX_AZ = 1'b1;

  localparam logic ACT_ACCUM = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  function automatic logic [16:0] pt_edge(input logic [4:0] k);
    logic [16:0] e;
    case (k)
      5'd0:  e = 17'd30;
      5'd1:  e = 17'd40;
      5'd2:  e = 17'd50;
      5'd3:  e = 17'd60;
      5'd4:  e = 17'd80;
      5'd5:  e = 17'd100;
      5'd6:  e = 17'd125;
      5'd7:  e = 17'd150;
      5'd8:  e = 17'd200;
      5'd9:  e = 17'd250;
      5'd10: e = 17'd300;
      5'd11: e = 17'd350;
      5'd12: e = 17'd400;
      5'd13: e = 17'd500;
      5'd14: e = 17'd600;
      5'd15: e = 17'd700;
      5'd16: e = 17'd800;
      5'd17: e = 17'd1000;
      5'd18: e = 17'd1200;
      5'd19: e = 17'd1400;
      default: e = 17'd100000;
    endcase
    return e;
  endfunction

  function automatic logic [21:0] cordic_atan(input logic [3:0] i);
    logic [21:0] a;
    case (i)
      4'd0:  a = 22'd2097152;
      4'd1:  a = 22'd1238021;
      4'd2:  a = 22'd654136;
      4'd3:  a = 22'd332050;
      4'd4:  a = 22'd166669;
      4'd5:  a = 22'd83416;
      4'd6:  a = 22'd41718;
      4'd7:  a = 22'd20860;
      4'd8:  a = 22'd10430;
      4'd9:  a = 22'd5215;
      4'd10: a = 22'd2608;
      4'd11: a = 22'd1304;
      4'd12: a = 22'd652;
      4'd13: a = 22'd326;
      4'd14: a = 22'd163;
      default: a = 22'd81;
    endcase
    return a;
  endfunction

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BIN,
    ST_IDX,
    ST_CORDIC,
    ST_MUL,
    ST_RD,
    ST_ADD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic clear_step;   // write zero at clear address, advance
    logic load;         // capture input word
    logic calc_idx;     // register pt/eta bins and vertex-window check
    logic cordic_init;
    logic cordic_step;
    logic mul;
    logic rd;           // issue store read
    logic add;          // saturating add and write back, or latch read data
    logic out_load;     // load output register
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic cordic_done;
    logic is_read;
    logic ok;
  } stat_t;

endpackage

// File: rtl/bhsa_ram.sv
// ============================================================================
// bhsa_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ============================================================================
module bhsa_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/bhsa_ctrl.sv
// ============================================================================
// bhsa_ctrl: sequencing controller
// Runs the clearing pass after reset, then steps each word through binning,
// CORDIC, multiply, read-modify-write and output; reads and rejects skip some.
// ============================================================================
module bhsa_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  input  logic             out_busy,
  input  bhsa_pkg::stat_t  stat,
  output logic             in_ready,
  output bhsa_pkg::cmd_t   cmd
);

  bhsa_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bhsa_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bhsa_pkg::ST_CLEAR:  if (stat.clear_done) state_nxt = bhsa_pkg::ST_IDLE;
      bhsa_pkg::ST_IDLE:   if (in_fire) state_nxt = bhsa_pkg::ST_BIN;
      bhsa_pkg::ST_BIN:    state_nxt = bhsa_pkg::ST_IDX;
      bhsa_pkg::ST_IDX: begin
        if (stat.is_read) state_nxt = stat.ok ? bhsa_pkg::ST_RD : bhsa_pkg::ST_OUT;
        else if (stat.ok) state_nxt = bhsa_pkg::ST_CORDIC;
        else state_nxt = bhsa_pkg::ST_OUT;
      end
      bhsa_pkg::ST_CORDIC: if (stat.cordic_done) state_nxt = bhsa_pkg::ST_MUL;
      bhsa_pkg::ST_MUL:    state_nxt = bhsa_pkg::ST_RD;
      bhsa_pkg::ST_RD:     state_nxt = bhsa_pkg::ST_ADD;
      bhsa_pkg::ST_ADD:    state_nxt = bhsa_pkg::ST_OUT;
      bhsa_pkg::ST_OUT:    if (!out_busy) state_nxt = bhsa_pkg::ST_IDLE;
      default:             state_nxt = bhsa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      bhsa_pkg::ST_CLEAR:  cmd.clear_step = 1'b1;
      bhsa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = 1'b1;
      end
      bhsa_pkg::ST_BIN:    cmd.calc_idx = 1'b1;
      bhsa_pkg::ST_IDX:    cmd.cordic_init = 1'b1;
      bhsa_pkg::ST_CORDIC: cmd.cordic_step = 1'b1;
      bhsa_pkg::ST_MUL:    cmd.mul = 1'b1;
      bhsa_pkg::ST_RD:     cmd.rd = 1'b1;
      bhsa_pkg::ST_ADD:    cmd.add = 1'b1;
      bhsa_pkg::ST_OUT:    cmd.out_load = !out_busy;
      default: ;
    endcase
  end

  a_clear_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bhsa_pkg::ST_CLEAR) |-> !in_ready)
    else $error("input taken during clearing pass");
  a_out_one: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (state_r == bhsa_pkg::ST_IDLE))
    else $error("output load not followed by idle");
  a_add_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.add |-> $past(cmd.rd))
    else $error("add without read");

endmodule

// File: rtl/bhsa_dp.sv
// ============================================================================
// bhsa_dp: accumulator datapath
// Binning, shared sin/cos CORDIC, weight multiply, five accumulator RAMs
// with saturating update, and the result register.
// ============================================================================
module bhsa_dp #(
  parameter int PT_BINS   = bhsa_pkg::PT_BINS_DEF,
  parameter int ETA_BINS  = bhsa_pkg::ETA_BINS_DEF,
  parameter int CENT_BINS = bhsa_pkg::CENT_BINS_DEF,
  parameter int ACC_WIDTH = bhsa_pkg::ACC_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bhsa_pkg::cmd_t        cmd,
  output bhsa_pkg::stat_t       stat,
  input  logic                  act,
  input  logic signed [13:0]    eta,
  input  logic [15:0]           phi,
  input  logic [19:0]           pt,
  input  logic [15:0]           wt,
  input  logic signed [8:0]     cent,
  input  logic signed [11:0]    vz,
  input  logic [15:0]           rd_index,
  input  logic                  cfg_we,
  input  logic                  cfg_idx,
  input  logic signed [11:0]    cfg_val,
  input  logic                  out_ack,
  output logic                  out_valid,
  output logic                  o_acc,
  output logic [4:0]            o_pb,
  output logic [3:0]            o_eb,
  output logic [47:0]           o_s1,
  output logic [47:0]           o_c1,
  output logic [47:0]           o_s2,
  output logic [47:0]           o_c2,
  output logic [47:0]           o_w
);

  localparam int DEPTH = PT_BINS * ETA_BINS * CENT_BINS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = (AW > 16) ? AW : 16;
  localparam int ROWB  = ETA_BINS * CENT_BINS;

  // configuration
  logic signed [11:0] min_az_r, max_az_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_az_r <= bhsa_pkg::MIN_AZ_RST;
      max_az_r <= bhsa_pkg::MAX_AZ_RST;
    end else if (cfg_we) begin
      if (cfg_idx == bhsa_pkg::CFG_MIN_AZ) min_az_r <= cfg_val;
      else                                 max_az_r <= cfg_val;
    end
  end

  // captured input
  logic               act_r;
  logic signed [13:0] eta_r;
  logic [15:0]        phi_r;
  logic [19:0]        pt_r;
  logic [15:0]        wt_r;
  logic signed [8:0]  cent_r;
  logic signed [11:0] vz_r;
  logic [15:0]        ridx_r;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= act; eta_r <= eta; phi_r <= phi; pt_r <= pt;
      wt_r <= wt; cent_r <= cent; vz_r <= vz; ridx_r <= rd_index;
    end
  end

  // binning (stage 1)
  logic [4:0]  pb_nxt, pb_r;
  logic [3:0]  eb_nxt, eb_r;
  logic        ebv_nxt, ebv_r;     // eta bin inside 0..ETA_BINS-1
  logic        vz_ok_nxt, vz_ok_r;
  logic signed [14:0] n_eta;
  logic [12:0] az;
  logic [4:0]  ebf;

  always_comb begin
    pb_nxt = 5'd0;
    for (int k = 1; k < bhsa_pkg::PT_EDGE_NUM; k++) begin
      if ({1'b0, pt_r} > {4'd0, bhsa_pkg::pt_edge(5'(k))}) pb_nxt = 5'(k);
    end
    n_eta = 15'(eta_r) + 15'sd2400;
    // Floor by 400 via compare ladder; every bin past 15 reads 15, so the
    // ladder stops at 18.
    ebf = 5'd0;
    for (int j = 1; j < 19; j++) begin
      if (n_eta >= 15'(j * bhsa_pkg::ETA_STEP)) ebf = 5'(j);
    end
    ebv_nxt = !n_eta[14] && (32'(ebf) < ETA_BINS);
    eb_nxt  = (n_eta[14] || ebf > 5'd15) ? 4'd15 : ebf[3:0];
    az = vz_r[11] ? 13'(-14'(vz_r)) : 13'(vz_r);
    vz_ok_nxt = !($signed({1'b0, az}) > 14'(max_az_r)) &&
                !($signed({1'b0, az}) < 14'(min_az_r));
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_idx) begin
      pb_r <= pb_nxt; eb_r <= eb_nxt; ebv_r <= ebv_nxt; vz_ok_r <= vz_ok_nxt;
    end
  end

  // index and acceptance (stage 2, combinational from registered bins)
  logic [AW-1:0] idx_acc;
  logic          ok_acc, ok_rd;
  logic [4:0]    rpb;
  logic [3:0]    reb;
  logic [31:0]   rrem;
  always_comb begin
    idx_acc = AW'((32'(pb_r) * ETA_BINS + 32'(eb_r)) * CENT_BINS + 32'(cent_r[7:0]));
    ok_acc  = vz_ok_r && (32'(pb_r) < PT_BINS) && ebv_r && !cent_r[8] &&
              (32'(cent_r[7:0]) < CENT_BINS);
    ok_rd   = (32'(ridx_r) < DEPTH);
    // Read index decode by compare ladders against multiples of the row sizes.
    rpb = 5'd0;
    for (int k = 1; k < PT_BINS; k++) begin
      if (32'(ridx_r) >= k * ROWB) rpb = 5'(k);
    end
    rrem = 32'(ridx_r) - 32'(rpb) * ROWB;
    reb = 4'd0;
    for (int j = 1; j < ETA_BINS; j++) begin
      if (rrem >= j * CENT_BINS) reb = 4'(j);
    end
  end

  logic [AW-1:0] idx_r;
  logic          ok_r;
  logic [4:0]    fpb_r;
  logic [3:0]    feb_r;
  always_ff @(posedge clk) begin
    if (cmd.cordic_init) begin
      idx_r <= act_r ? AW'(ridx_r) : idx_acc;
      ok_r  <= act_r ? ok_rd : ok_acc;
      fpb_r <= act_r ? (ok_rd ? rpb : 5'd0) : pb_r;
      feb_r <= act_r ? (ok_rd ? reb : 4'd0) : eb_r;
    end
  end

  assign stat.is_read = act_r;
  assign stat.ok      = act_r ? ok_rd : ok_acc;

  // two CORDIC lanes, one for phi and one for 2*phi, sharing the counter
  logic signed [19:0] x_r [2], y_r [2];
  logic signed [24:0] z_r [2];
  logic [1:0]         q_r [2];
  logic [3:0]         it_r;
  logic [15:0]        ang [2];
  assign ang[0] = phi_r;
  assign ang[1] = {phi_r[14:0], 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.cordic_init) begin
      it_r <= '0;
      for (int l = 0; l < 2; l++) begin
        x_r[l] <= 20'sd19899;
        y_r[l] <= '0;
        z_r[l] <= 25'({ang[l][13:0], 8'd0});
        q_r[l] <= ang[l][15:14];
      end
    end else if (cmd.cordic_step) begin
      it_r <= it_r + 4'd1;
      for (int l = 0; l < 2; l++) begin
        if (!z_r[l][24]) begin
          x_r[l] <= x_r[l] - (y_r[l] >>> it_r);
          y_r[l] <= y_r[l] + (x_r[l] >>> it_r);
          z_r[l] <= z_r[l] - 25'(bhsa_pkg::cordic_atan(it_r));
        end else begin
          x_r[l] <= x_r[l] + (y_r[l] >>> it_r);
          y_r[l] <= y_r[l] - (x_r[l] >>> it_r);
          z_r[l] <= z_r[l] + 25'(bhsa_pkg::cordic_atan(it_r));
        end
      end
    end
  end
  assign stat.cordic_done = (it_r == 4'(bhsa_pkg::CORDIC_STEPS - 1));

  function automatic logic signed [16:0] clamp15(input logic signed [19:0] v);
    if (v > 20'sd32767)  return 17'sd32767;
    if (v < -20'sd32767) return -17'sd32767;
    return 17'(v);
  endfunction

  logic signed [16:0] sn [2], cs [2], sv [2], cv [2];
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      sv[l] = clamp15(y_r[l]);
      cv[l] = clamp15(x_r[l]);
      case (q_r[l])
        2'd0:    begin sn[l] = sv[l];  cs[l] = cv[l];  end
        2'd1:    begin sn[l] = cv[l];  cs[l] = -sv[l]; end
        2'd2:    begin sn[l] = -sv[l]; cs[l] = -cv[l]; end
        default: begin sn[l] = -cv[l]; cs[l] = sv[l];  end
      endcase
    end
  end

  // products, 17x17 signed each
  logic signed [33:0] p_r [4];
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      p_r[0] <= $signed({1'b0, wt_r}) * sn[0];
      p_r[1] <= $signed({1'b0, wt_r}) * cs[0];
      p_r[2] <= $signed({1'b0, wt_r}) * sn[1];
      p_r[3] <= $signed({1'b0, wt_r}) * cs[1];
    end
  end

  // clearing pass address
  logic [AW-1:0] clr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (cmd.clear_step && !stat.clear_done) clr_r <= clr_r + AW'(1);
  end
  assign stat.clear_done = (32'(clr_r) == DEPTH - 1);

  // stores
  logic [ACC_WIDTH-1:0] rdat [5], wdat [5];
  logic                 we;
  logic [AW-1:0]        addr;
  assign we   = cmd.clear_step || (cmd.add && !act_r);
  assign addr = cmd.clear_step ? clr_r : idx_r;

  for (genvar g = 0; g < 5; g++) begin : g_store
    bhsa_ram #(.WIDTH(ACC_WIDTH), .DEPTH(DEPTH)) u_ram (
      .clk(clk), .we(we), .addr(addr),
      .wdata(cmd.clear_step ? '0 : wdat[g]), .rdata(rdat[g]));
  end

  localparam logic signed [ACC_WIDTH:0] SMAX = (ACC_WIDTH+1)'((65'sd1 <<< (ACC_WIDTH-1)) - 1);
  localparam logic signed [ACC_WIDTH:0] SMIN = -SMAX - 1;

  logic signed [ACC_WIDTH:0] ssum [4];
  logic [ACC_WIDTH:0]        usum;
  always_comb begin
    for (int s = 0; s < 4; s++) begin
      ssum[s] = $signed({rdat[s][ACC_WIDTH-1], rdat[s]}) + (ACC_WIDTH+1)'(p_r[s]);
      if (ssum[s] > SMAX)      wdat[s] = SMAX[ACC_WIDTH-1:0];
      else if (ssum[s] < SMIN) wdat[s] = SMIN[ACC_WIDTH-1:0];
      else                     wdat[s] = ssum[s][ACC_WIDTH-1:0];
    end
    usum = {1'b0, rdat[4]} + (ACC_WIDTH+1)'(wt_r);
    wdat[4] = usum[ACC_WIDTH] ? '1 : usum[ACC_WIDTH-1:0];
  end

  logic [ACC_WIDTH-1:0] res_r [5];
  always_ff @(posedge clk) begin
    if (cmd.add) begin
      for (int s = 0; s < 5; s++) res_r[s] <= act_r ? rdat[s] : wdat[s];
    end
  end

  // output register
  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ack) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_acc <= ok_r;
      o_pb  <= fpb_r;
      o_eb  <= feb_r;
      o_s1  <= ok_r ? 48'(signed'(res_r[0])) : '0;
      o_c1  <= ok_r ? 48'(signed'(res_r[1])) : '0;
      o_s2  <= ok_r ? 48'(signed'(res_r[2])) : '0;
      o_c2  <= ok_r ? 48'(signed'(res_r[3])) : '0;
      o_w   <= ok_r ? 48'(res_r[4]) : '0;
    end
  end
  assign out_valid = out_valid_r;

  a_zero_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !o_acc) |-> (o_w == '0 && o_s1 == '0))
    else $error("rejected word carries sums");
  a_rd_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.add && act_r) |-> !we)
    else $error("read word wrote the store");
  a_clr_addr: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clear_done |-> cmd.clear_step || $stable(clr_r))
    else $error("clear address moved after pass");

endmodule

// File: rtl/binned_harmonic_sum_accumulator_core.sv
// Flow: an accepted track passes the states BIN, IDX, CORDIC, MUL, RD, ADD and OUT;
// a read skips CORDIC and MUL, and a rejected track goes from IDX straight to OUT.
// Throughput: one word at a time; no new word is taken until the last has left OUT,
// and OUT holds while the output stalls; the 16-step CORDIC and the single-port store are shared.
// Reset: synchronous active-low; afterwards a clearing pass zeroes all
// PT_BINS*ETA_BINS*CENT_BINS store entries (48000 by default) before input is taken.
// ============================================================================
// binned_harmonic_sum_accumulator_core: binned harmonic-sum accumulator
// Bins each track, adds weighted sin/cos of phi and 2*phi and the weight to
// saturating per-bin sums, and reads sums back by index.
// ============================================================================
module binned_harmonic_sum_accumulator_core #(
  parameter int PT_BINS   = bhsa_pkg::PT_BINS_DEF,
  parameter int ETA_BINS  = bhsa_pkg::ETA_BINS_DEF,
  parameter int CENT_BINS = bhsa_pkg::CENT_BINS_DEF,
  parameter int ACC_WIDTH = bhsa_pkg::ACC_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // track_eta[13:0], track_phi[29:14], track_pt[49:30], track_weight[65:50],
  // centrality[74:66], vertex_z[86:75], read_index[102:87], zero pad
  input  logic [103:0] in_tdata,
  input  logic         in_tuser,    // action
  output logic         out_tvalid,
  input  logic         out_tready,
  // accepted[0], pt_bin[5:1], eta_bin[9:6], sum_sin_first[57:10],
  // sum_cos_first[105:58], sum_sin_second[153:106], sum_cos_second[201:154],
  // sum_weight[249:202], zero pad
  output logic [255:0] out_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [11:0]  cfg_data
);

  bhsa_pkg::cmd_t  cmd;
  bhsa_pkg::stat_t stat;
  logic            in_fire;
  logic            o_acc;
  logic [4:0]      o_pb;
  logic [3:0]      o_eb;
  logic [47:0]     o_s1, o_c1, o_s2, o_c2, o_w;

  assign in_fire = in_tvalid && in_tready;

  bhsa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
    .out_busy(out_tvalid && !out_tready), .stat(stat),
    .in_ready(in_tready), .cmd(cmd));

  bhsa_dp #(.PT_BINS(PT_BINS), .ETA_BINS(ETA_BINS), .CENT_BINS(CENT_BINS),
            .ACC_WIDTH(ACC_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .act(in_tuser), .eta(in_tdata[13:0]), .phi(in_tdata[29:14]),
    .pt(in_tdata[49:30]), .wt(in_tdata[65:50]), .cent(in_tdata[74:66]),
    .vz(in_tdata[86:75]), .rd_index(in_tdata[102:87]),
    .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_val(cfg_data),
    .out_ack(out_tready), .out_valid(out_tvalid),
    .o_acc(o_acc), .o_pb(o_pb), .o_eb(o_eb), .o_s1(o_s1), .o_c1(o_c1),
    .o_s2(o_s2), .o_c2(o_c2), .o_w(o_w));

  assign out_tdata = {6'd0, o_w, o_c2, o_s2, o_c1, o_s1, o_eb, o_pb, o_acc};

endmodule

// File: bench/tb_binned_harmonic_sum_accumulator_core.sv
// ============================================================================
// tb_binned_harmonic_sum_accumulator_core: self-checking bench of the core
// A directed table of tracks and reads is followed by random traffic over
// several vertex-z windows. Typed table rows are checked against their listed result,
// the rest against a bench-side model of binning, CORDIC sine/cosine and saturation.
// ============================================================================
`timescale 1ns / 100ps

module tb_binned_harmonic_sum_accumulator_core;

  localparam int DEPTH      = bhsa_pkg::PT_BINS_DEF * bhsa_pkg::ETA_BINS_DEF *
                              bhsa_pkg::CENT_BINS_DEF;
  localparam int IDLE_LIMIT = 200000;
  localparam int N_RANDOM   = 650;
  localparam longint SMAX   = 64'sd140737488355327;
  localparam longint UMAX   = 64'sd281474976710655;

  localparam longint EDGES [21] = '{30, 40, 50, 60, 80, 100, 125, 150, 200, 250, 300,
    350, 400, 500, 600, 700, 800, 1000, 1200, 1400, 100000};
  localparam longint ATANS [16] = '{2097152, 1238021, 654136, 332050, 166669, 83416,
    41718, 20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

  typedef struct {
    logic               act;
    logic signed [13:0] eta;
    logic [15:0]        phi;
    logic [19:0]        pt;
    logic [15:0]        w;
    logic signed [8:0]  cent;
    logic signed [11:0] vz;
    logic [15:0]        ridx;
  } track_t;

  // Members run from the top bit down, so acc lands in bit 0 of the word.
  typedef struct packed {
    logic [47:0] sw, c2, s2, c1, s1;
    logic [3:0]  eb;
    logic [4:0]  pb;
    logic        acc;
  } sums_t;

  typedef struct {
    track_t trk;
    bit     typed;
    sums_t  res;
  } row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [103:0] in_tdata = '0;
  logic         in_tuser = bhsa_pkg::ACT_ACCUM;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [255:0] out_tdata;
  logic         cfg_we = 1'b0;
  logic         cfg_index = bhsa_pkg::CFG_MIN_AZ;
  logic [11:0]  cfg_data = '0;

  logic signed [11:0] win_lo [4] = '{-12'sd2048, 12'sd0, 12'sd200, 12'sd2047};
  logic signed [11:0] win_hi [4] = '{12'sd2047, 12'sd0, 12'sd1500, -12'sd2048};

  binned_harmonic_sum_accumulator_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Bench copy of the accumulator store and the vertex window.
  longint sin1_sums[int], cos1_sums[int], sin2_sums[int], cos2_sums[int], wt_sums[int];
  longint az_lo = -960, az_hi = 960;
  int     hit_bins[$];
  sums_t  pending_sums[$];
  row_t   dir_rows[$];
  int     n_errors = 0;
  bit     calm = 1'b0;
  int     idle_cycles = 0;

  function automatic longint peek(ref longint m[int], input int i);
    return m.exists(i) ? m[i] : 0;
  endfunction

  function automatic longint clamp15(longint v);
    if (v > 32767) return 32767;
    if (v < -32767) return -32767;
    return v;
  endfunction

  function automatic void cordic_sincos(input logic [15:0] ang, output longint s,
                                        output longint c);
    longint x, y, z, dx, dy, sv, cv;
    x = 19899;
    y = 0;
    z = longint'(ang[13:0]) << 8;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATANS[i];
      end else begin
        x += dx; y -= dy; z += ATANS[i];
      end
    end
    sv = clamp15(y);
    cv = clamp15(x);
    case (ang[15:14])
      2'd0: begin s = sv;  c = cv;  end
      2'd1: begin s = cv;  c = -sv; end
      2'd2: begin s = -sv; c = -cv; end
      default: begin s = -cv; c = sv; end
    endcase
  endfunction

  function automatic longint sat_signed(longint acc, longint a);
    if (a > 0 && acc > SMAX - a) return SMAX;
    if (a < 0 && acc < -SMAX - 1 - a) return -SMAX - 1;
    return acc + a;
  endfunction

  // Works out the output word of one track or read and updates the store.
  function automatic sums_t bin_and_accumulate(track_t t);
    sums_t  r;
    longint pt, eta_n, ebin, az, sa, ca, sb, cb, w;
    int     k, idx;
    bit     ok;
    r = '0;
    if (t.act == bhsa_pkg::ACT_READ) begin
      idx = int'(t.ridx);
      if (idx < DEPTH) begin
        r.acc = 1'b1;
        r.pb  = 5'(idx / (bhsa_pkg::ETA_BINS_DEF * bhsa_pkg::CENT_BINS_DEF));
        r.eb  = 4'((idx / bhsa_pkg::CENT_BINS_DEF) % bhsa_pkg::ETA_BINS_DEF);
        r.s1  = 48'(peek(sin1_sums, idx));
        r.c1  = 48'(peek(cos1_sums, idx));
        r.s2  = 48'(peek(sin2_sums, idx));
        r.c2  = 48'(peek(cos2_sums, idx));
        r.sw  = 48'(peek(wt_sums, idx));
      end
      return r;
    end
    pt = longint'(t.pt);
    k = 1;
    while (k <= 20 && pt > EDGES[k]) k++;
    r.pb = 5'(k - 1);
    eta_n = longint'(t.eta) + bhsa_pkg::ETA_OFFSET;
    ebin = (eta_n >= 0) ? eta_n / bhsa_pkg::ETA_STEP : -1;
    r.eb = (ebin >= 0 && ebin <= 15) ? 4'(ebin) : 4'd15;
    az = (t.vz < 0) ? -longint'(t.vz) : longint'(t.vz);
    ok = !(az > az_hi || az < az_lo) && (k - 1 < bhsa_pkg::PT_BINS_DEF) &&
         (ebin >= 0 && ebin < bhsa_pkg::ETA_BINS_DEF) &&
         (t.cent >= 0 && t.cent < bhsa_pkg::CENT_BINS_DEF);
    if (!ok) return r;
    idx = ((k - 1) * bhsa_pkg::ETA_BINS_DEF + int'(ebin)) * bhsa_pkg::CENT_BINS_DEF +
          int'(t.cent);
    w = longint'(t.w);
    cordic_sincos(t.phi, sa, ca);
    cordic_sincos({t.phi[14:0], 1'b0}, sb, cb);
    sin1_sums[idx] = sat_signed(peek(sin1_sums, idx), w * sa);
    cos1_sums[idx] = sat_signed(peek(cos1_sums, idx), w * ca);
    sin2_sums[idx] = sat_signed(peek(sin2_sums, idx), w * sb);
    cos2_sums[idx] = sat_signed(peek(cos2_sums, idx), w * cb);
    wt_sums[idx] = (peek(wt_sums, idx) > UMAX - w) ? UMAX : peek(wt_sums, idx) + w;
    hit_bins.push_back(idx);
    r.acc = 1'b1;
    r.s1 = 48'(sin1_sums[idx]);
    r.c1 = 48'(cos1_sums[idx]);
    r.s2 = 48'(sin2_sums[idx]);
    r.c2 = 48'(cos2_sums[idx]);
    r.sw = 48'(wt_sums[idx]);
    return r;
  endfunction

  // Result side: random stalls, compare each output word with the oldest expectation.
  always @(posedge clk) begin
    sums_t got, want;
    out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 23);
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[249:0];
      if (pending_sums.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("ERROR: output word with nothing expected: %h", got);
      end else begin
        want = pending_sums.pop_front();
        if (got !== want) begin
          n_errors++;
          if (n_errors <= 10)
            $display({"ERROR: acc %b/%b pt %0d/%0d eta %0d/%0d s1 %h/%h c1 %h/%h ",
                      "s2 %h/%h c2 %h/%h w %h/%h (exp/act)"},
                     want.acc, got.acc, want.pb, got.pb, want.eb, got.eb, want.s1, got.s1,
                     want.c1, got.c1, want.s2, got.s2, want.c2, got.c2, want.sw, got.sw);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_word(input track_t t, input bit typed, input sums_t typed_res);
    sums_t p;
    if (!calm && $urandom_range(99) < 23) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= t.act;
    in_tdata  <= {1'b0, t.ridx, t.vz, t.cent, t.w, t.pt, t.phi, t.eta};
    do @(posedge clk); while (!in_tready);
    p = bin_and_accumulate(t);
    pending_sums.push_back(typed ? typed_res : p);
  endtask

  // Drains the pipeline, then sets a new vertex window while the core is idle.
  task automatic set_window(input logic signed [11:0] lo, input logic signed [11:0] hi);
    in_tvalid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= bhsa_pkg::CFG_MIN_AZ;
    cfg_data <= lo;
    @(posedge clk);
    cfg_index <= bhsa_pkg::CFG_MAX_AZ;
    cfg_data <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    az_lo = lo;
    az_hi = hi;
  endtask

  task automatic add_row(input logic act, input int eta, input int phi, input int pt,
                         input int w, input int cent, input int vz, input int ridx,
                         input bit typed, input logic acc, input int pb, input int eb);
    row_t r;
    r.trk = '{act, 14'(eta), 16'(phi), 20'(pt), 16'(w), 9'(cent), 12'(vz), 16'(ridx)};
    r.typed = typed;
    r.res = '0;
    r.res.acc = acc;
    r.res.pb = 5'(pb);
    r.res.eb = 4'(eb);
    dir_rows.push_back(r);
  endtask

  initial begin
    track_t t;
    int r;

    // Reads of a freshly cleared store, then tracks past eta, pt, cent and vz limits.
    add_row(bhsa_pkg::ACT_READ,  0, 0, 0, 0, 0, 0, 0,     1, 1, 0, 0);
    add_row(bhsa_pkg::ACT_READ,  0, 0, 0, 0, 0, 0, 47999, 1, 1, 19, 11);
    add_row(bhsa_pkg::ACT_READ,  0, 0, 0, 0, 0, 0, 48000, 1, 0, 0, 0);
    add_row(bhsa_pkg::ACT_READ,  0, 0, 0, 0, 0, 0, 65535, 1, 0, 0, 0);
    add_row(bhsa_pkg::ACT_ACCUM, 0, 0, 0, 4096, 0, 0, 0,  0, 0, 0, 0);
    add_row(bhsa_pkg::ACT_ACCUM, 0, 0, 0, 4096, -1, 0, 0, 1, 0, 0, 6);
    add_row(bhsa_pkg::ACT_ACCUM, 0, 0, 0, 4096, 200, 0, 0, 1, 0, 0, 6);
    add_row(bhsa_pkg::ACT_ACCUM, 0, 0, 0, 4096, 255, 0, 0, 1, 0, 0, 6);
    add_row(bhsa_pkg::ACT_ACCUM, -2401, 0, 0, 4096, 5, 0, 0, 1, 0, 0, 15);
    add_row(bhsa_pkg::ACT_ACCUM, -2400, 100, 0, 4096, 5, 0, 0, 0, 0, 0, 0);
    add_row(bhsa_pkg::ACT_ACCUM, 2399, 200, 0, 4096, 5, 0, 0,  0, 0, 0, 0);
    add_row(bhsa_pkg::ACT_ACCUM, 2400, 0, 0, 4096, 5, 0, 0,    1, 0, 0, 12);
    add_row(bhsa_pkg::ACT_ACCUM, 5000, 0, 0, 4096, 5, 0, 0,    1, 0, 0, 15);
    add_row(bhsa_pkg::ACT_ACCUM, -5000, 0, 0, 4096, 5, 0, 0,   1, 0, 0, 15);
    add_row(bhsa_pkg::ACT_ACCUM, 0, 0, 100001, 4096, 5, 0, 0,  1, 0, 20, 6);
    add_row(bhsa_pkg::ACT_ACCUM, 0, 0, 1048575, 4096, 5, 0, 0, 1, 0, 20, 6);
    add_row(bhsa_pkg::ACT_ACCUM, 0, 300, 41, 4096, 7, 0, 0,    0, 0, 0, 0);
    add_row(bhsa_pkg::ACT_ACCUM, 0, 400, 100000, 4096, 7, 0, 0, 0, 0, 0, 0);
    add_row(bhsa_pkg::ACT_ACCUM, 0, 0, 0, 4096, 0, 961, 0,     1, 0, 0, 6);
    add_row(bhsa_pkg::ACT_ACCUM, 0, 0, 0, 4096, 0, -2048, 0,   1, 0, 0, 6);
    add_row(bhsa_pkg::ACT_ACCUM, 0, 16384, 0, 65535, 0, -960, 0, 0, 0, 0, 0);
    add_row(bhsa_pkg::ACT_ACCUM, 0, 32768, 0, 65535, 0, 960, 0,  0, 0, 0, 0);
    add_row(bhsa_pkg::ACT_ACCUM, 0, 65535, 0, 0, 0, 0, 0,       0, 0, 0, 0);
    add_row(bhsa_pkg::ACT_READ,  0, 0, 0, 0, 0, 0, 1200,        0, 0, 0, 0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_word(dir_rows[i].trk, dir_rows[i].typed, dir_rows[i].res);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 130 == 0 && n > 0) set_window(win_lo[n / 130 - 1], win_hi[n / 130 - 1]);
      calm = (n >= 260 && n < 360);
      r = $urandom_range(99);
      t = '{bhsa_pkg::ACT_ACCUM, 14'($urandom), 16'($urandom), 20'($urandom),
            16'($urandom), 9'($urandom), 12'($urandom), 16'($urandom)};
      if (r < 15) begin
        t.act = bhsa_pkg::ACT_READ;
        if (hit_bins.size() != 0 && $urandom_range(9) < 7)
          t.ridx = 16'(hit_bins[$urandom_range(hit_bins.size() - 1)]);
      end else if (r < 85) begin
        // Well-formed track, packed into a few bins so sums build up.
        t.eta  = 14'($urandom_range(4799) - 2400);
        t.pt   = ($urandom_range(9) < 8) ? 20'($urandom_range(1500)) : 20'($urandom);
        t.cent = ($urandom_range(9) < 7) ? 9'($urandom_range(3)) : 9'($urandom_range(199));
        t.vz   = 12'($urandom_range(2047) - 1024);
      end
      send_word(t, 1'b0, '0);
    end
    set_window(-12'sd960, 12'sd960);

    repeat (40) @(posedge clk);
    if (n_errors == 0 && pending_sums.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: binned_harmonic_sum_accumulator_core.f
rtl/bhsa_pkg.sv
rtl/bhsa_ram.sv
rtl/bhsa_ctrl.sv
rtl/bhsa_dp.sv
rtl/binned_harmonic_sum_accumulator_core.sv
bench/tb_binned_harmonic_sum_accumulator_core.sv
